[rtl/core/cmavg_pkg.sv]
package cmavg_pkg;

  // window length register, fixed by the register map
  localparam int CFG_W     = 7;
  localparam int CFG_RESET = 8;

endpackage

[rtl/core/cmavg_ram.sv]
module cmavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/cmavg_div.sv]
module cmavg_div #(
  parameter int SUM_W = 22,
  parameter int DIV_W = 7,
  parameter int Q_W   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [DIV_W-1:0]        divisor,
  output logic                    ready,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic [Q_W-1:0]          res_data
);

  localparam int CNT_W = $clog2(SUM_W);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_DONE
  } div_state_t;

  div_state_t         state_r;
  logic [SUM_W-1:0]   mag_r;
  logic [DIV_W-1:0]   rem_r;
  logic [DIV_W-1:0]   den_r;
  logic               neg_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               res_valid_r;
  logic [Q_W-1:0]     res_data_r;

  logic [DIV_W:0]     rem_sh;
  logic               q_bit;
  logic [DIV_W-1:0]   rem_nxt;
  logic [SUM_W-1:0]   quo_signed;

  // restoring step: one quotient bit per cycle, quotient shifts into mag_r
  always_comb begin
    rem_sh  = {rem_r, mag_r[SUM_W-1]};
    q_bit   = (rem_sh >= {1'b0, den_r});
    rem_nxt = q_bit ? DIV_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_W-1:0];
    quo_signed = neg_r ? (~mag_r + SUM_W'(1)) : mag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= D_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      if ((state_r == D_DONE) && (!res_valid_r || res_ready)) begin
        res_valid_r <= 1'b1;
      end else if (res_valid_r && res_ready) begin
        res_valid_r <= 1'b0;
      end
      case (state_r)
        D_IDLE: begin
          if (start) begin
            neg_r   <= dividend[SUM_W-1];
            mag_r   <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
            den_r   <= divisor;
            rem_r   <= '0;
            cnt_r   <= CNT_W'(SUM_W - 1);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          mag_r <= {mag_r[SUM_W-2:0], q_bit};
          rem_r <= rem_nxt;
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_r <= D_DONE;
          end
        end
        D_DONE: begin
          if (!res_valid_r || res_ready) begin
            res_data_r  <= quo_signed[Q_W-1:0];
            state_r     <= D_IDLE;
          end
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  assign ready     = (state_r == D_IDLE);
  assign res_valid = res_valid_r;
  assign res_data  = res_data_r;

endmodule

[rtl/core/causal_moving_average_padded_top.sv]
// path: a word accepted in S_IDLE passes S_UPD and S_DIVW, then the bit-serial divider, to out_tvalid
// the bit-serial divider after the sum update sets the word rate; S_DIVW holds until it is free
// the front end takes a word only in S_IDLE (ring read, update and write-back, divider hand-off)
// a window write triggers a recompute over min(fill, window) ring entries, padded with the first sample
// reset: synchronous active-low rst_n clears pointer, fill, sum, first sample, window = 8
module causal_moving_average_padded_top
  import cmavg_pkg::*;
#(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [CFG_W-1:0]                      cfg_wr_data,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      in_tdata,   // sample
  input  logic                                  in_tuser,   // restart
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]      out_tdata   // average
);

  localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int PTR_W  = $clog2(MAX_WINDOW);
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW);
  localparam int PROD_W = WIN_W + 1 + SAMPLE_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_DIVW,
    S_SWEEP,
    S_SWFIN
  } ctl_state_t;

  ctl_state_t                    state_r;
  logic [CFG_W-1:0]              win_r;
  logic [PTR_W-1:0]              wp_r;
  logic [WIN_W-1:0]              fill_r;
  logic signed [SAMPLE_BITS-1:0] first_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic                          pend_r;

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic [WIN_W-1:0]              feff_r;
  logic [PTR_W-1:0]              wpe_r;

  logic [WIN_W-1:0]              used_r;
  logic [WIN_W-1:0]              cnt_r;
  logic [PTR_W-1:0]              sp_r;
  logic                          rdv_r;
  logic signed [SUM_W-1:0]       acc_r;

  logic [WIN_W-1:0]              w_eff;
  logic                          accept;
  logic                          restart;
  logic signed [SAMPLE_BITS-1:0] x_in;
  logic [PTR_W-1:0]              wp_eff;
  logic [WIN_W-1:0]              f_eff;
  logic [WIN_W-1:0]              back_idx;
  logic [PTR_W-1:0]              wp_inc;
  logic [PTR_W-1:0]              wp_dec;
  logic [PTR_W-1:0]              sp_dec;
  logic [WIN_W-1:0]              used_nxt;
  logic                          sweep_go;
  logic                          sweep_issue;

  logic                          ram_re;
  logic [PTR_W-1:0]              ram_raddr;
  logic                          ram_we;
  logic [SAMPLE_BITS-1:0]        ram_rdata;
  logic signed [SAMPLE_BITS-1:0] old_x;

  logic signed [PROD_W-1:0]      prod_wx;
  logic signed [PROD_W-1:0]      prod_pad;
  logic signed [SUM_W-1:0]       sum_nxt;
  logic signed [SUM_W-1:0]       sweep_sum_nxt;

  logic                          div_start;
  logic                          div_ready;
  logic [SAMPLE_BITS-1:0]        div_q;

  // window of zero counts as one, anything above the ring depth saturates
  always_comb begin
    if (win_r == '0) begin
      w_eff = WIN_W'(1);
    end else if (int'(win_r) > MAX_WINDOW) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff = WIN_W'(win_r);
    end
  end

  assign in_tready = (state_r == S_IDLE) && !pend_r;
  assign accept    = in_tvalid && in_tready;
  assign restart   = in_tuser;
  assign x_in      = in_tdata[SAMPLE_BITS-1:0];
  assign wp_eff    = restart ? '0 : wp_r;
  assign f_eff     = restart ? '0 : fill_r;
  assign sweep_go  = (state_r == S_IDLE) && pend_r;
  assign sweep_issue = (state_r == S_SWEEP) && (cnt_r < used_r);
  assign used_nxt  = (fill_r < w_eff) ? fill_r : w_eff;

  always_comb begin
    // slot of the word that leaves the window, read before this word overwrites it
    if (WIN_W'(wp_eff) >= w_eff) begin
      back_idx = WIN_W'(wp_eff) - w_eff;
    end else begin
      back_idx = WIN_W'(MAX_WINDOW) - w_eff + WIN_W'(wp_eff);
    end
    wp_inc = (wpe_r == PTR_W'(MAX_WINDOW - 1)) ? '0 : wpe_r + PTR_W'(1);
    wp_dec = (wp_r == '0) ? PTR_W'(MAX_WINDOW - 1) : wp_r - PTR_W'(1);
    sp_dec = (sp_r == '0) ? PTR_W'(MAX_WINDOW - 1) : sp_r - PTR_W'(1);
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = back_idx[PTR_W-1:0];
    if (accept) begin
      ram_re = 1'b1;
    end else if (sweep_issue) begin
      ram_re    = 1'b1;
      ram_raddr = sp_r;
    end
    ram_we = (state_r == S_UPD);
  end

  assign old_x = ram_rdata;

  always_comb begin
    prod_wx  = $signed({1'b0, w_eff}) * x_r;
    prod_pad = $signed({1'b0, WIN_W'(w_eff - used_r)}) * first_r;
    if (feff_r == '0) begin
      sum_nxt = prod_wx[SUM_W-1:0];
    end else if (feff_r < w_eff) begin
      // a padding copy of the first sample gives way to the new word
      sum_nxt = sum_r + SUM_W'(x_r) - SUM_W'(first_r);
    end else begin
      sum_nxt = sum_r + SUM_W'(x_r) - SUM_W'(old_x);
    end
    sweep_sum_nxt = acc_r + prod_pad[SUM_W-1:0];
  end

  assign div_start = (state_r == S_DIVW) && div_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      win_r   <= CFG_W'(CFG_RESET);
      wp_r    <= '0;
      fill_r  <= '0;
      first_r <= '0;
      sum_r   <= '0;
      pend_r  <= 1'b0;
      rdv_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end
      if (cfg_wr_en) begin
        pend_r <= 1'b1;
      end else if (sweep_go) begin
        pend_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            x_r     <= x_in;
            feff_r  <= f_eff;
            wpe_r   <= wp_eff;
            state_r <= S_UPD;
          end else if (sweep_go) begin
            used_r  <= used_nxt;
            cnt_r   <= '0;
            sp_r    <= wp_dec;
            acc_r   <= '0;
            rdv_r   <= 1'b0;
            state_r <= S_SWEEP;
          end
        end
        S_UPD: begin
          sum_r <= sum_nxt;
          wp_r  <= wp_inc;
          if (feff_r == '0) begin
            first_r <= x_r;
          end
          if (feff_r < WIN_W'(MAX_WINDOW)) begin
            fill_r <= feff_r + WIN_W'(1);
          end else begin
            fill_r <= feff_r;
          end
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (div_ready) begin
            state_r <= S_IDLE;
          end
        end
        S_SWEEP: begin
          // walk back from the newest word, one ring read per cycle
          rdv_r <= sweep_issue;
          if (sweep_issue) begin
            cnt_r <= cnt_r + WIN_W'(1);
            sp_r  <= sp_dec;
          end
          if (rdv_r) begin
            acc_r <= acc_r + SUM_W'(old_x);
          end
          if (!sweep_issue && !rdv_r) begin
            state_r <= S_SWFIN;
          end
        end
        S_SWFIN: begin
          sum_r   <= sweep_sum_nxt;
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  cmavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wpe_r),
    .wr_data (x_r),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  cmavg_div #(
    .SUM_W (SUM_W),
    .DIV_W (WIN_W),
    .Q_W   (SAMPLE_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (sum_r),
    .divisor   (w_eff),
    .ready     (div_ready),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_data  (div_q)
  );

  assign out_tdata = DATA_W'(div_q);

endmodule

[verif/tb_causal_moving_average_padded_top.sv]
`timescale 1ns / 1ps

module tb_causal_moving_average_padded_top;
  import cmavg_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_ITEMS = 1200;
  localparam int TAIL_CYCLES  = 60;
  localparam int LONG_HOLD    = 400;

  localparam logic [15:0] S_MAX = 16'h7fff;
  localparam logic [15:0] S_MIN = 16'h8000;

  class window_mean_board;
    localparam int DEPTH = 64;
    logic signed [15:0] history [DEPTH];
    int unsigned        wr_ptr;
    int unsigned        fill;
    logic signed [15:0] first_sample;
    logic [6:0]         window_reg;
    logic [15:0]        average_q [$];
    int                 errors;

    function new();
      wr_ptr       = 0;
      fill         = 0;
      first_sample = '0;
      window_reg   = 7'(cmavg_pkg::CFG_RESET);
      errors       = 0;
    endfunction

    task report_mismatch(input string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    function void set_window(input logic [6:0] len);
      window_reg = len;
    endfunction

    function int pending();
      return average_q.size();
    endfunction

    // one accepted sample word, predicts its padded window mean
    function void take_sample(input logic [15:0] s, input logic restart);
      longint      acc;
      int          w;
      int          used;
      int          j;
      if (restart) begin
        wr_ptr = 0;
        fill   = 0;
      end
      if (fill == 0) first_sample = s;
      history[wr_ptr] = s;
      wr_ptr = (wr_ptr + 1) % DEPTH;
      if (fill < DEPTH) fill++;
      w = window_reg;
      if (w == 0) w = 1;
      if (w > DEPTH) w = DEPTH;
      used = (fill < w) ? fill : w;
      acc = 0;
      for (j = 0; j < used; j++) begin
        acc += history[(wr_ptr + DEPTH - 1 - j) % DEPTH];
      end
      // missing positions count as copies of the series' first sample
      acc += longint'(w - used) * first_sample;
      average_q.push_back(16'(acc / w));
    endfunction

    task check_average(input logic [15:0] got);
      logic [15:0] exp;
      if (average_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word, average %h", got));
      end else begin
        exp = average_q.pop_front();
        if (got !== exp)
          report_mismatch($sformatf("average got %h expected %h", got, exp));
      end
    endtask

    task check_drained();
      if (average_q.size() != 0)
        report_mismatch($sformatf("%0d averages never arrived", average_q.size()));
    endtask
  endclass

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [6:0]  cfg_wr_data = '0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata    = '0;
  logic        in_tuser    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [15:0] out_tdata;

  window_mean_board board;
  bit               fast_mode    = 1'b0;
  int               hold_request = 0;
  longint           cycle_count  = 0;

  causal_moving_average_padded_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),   // sample
    .in_tuser    (in_tuser),   // restart
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)   // average
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("DONE: errors detected");
    $finish;
  end

  // valid stays high across back-to-back words, lowered only when a gap follows
  task automatic push_sample(input logic [15:0] s, input logic restart);
    int gap;
    gap = fast_mode ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= restart;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    board.take_sample(s, restart);
  endtask

  task automatic wait_averages_done();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_window(input logic [6:0] len);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    board.set_window(len);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0:       return S_MAX;
      1:       return S_MIN;
      2, 3:    return 16'(int'($urandom_range(0, 200)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [6:0] rand_window();
    case ($urandom_range(0, 9))
      0:       return 7'd1;
      1:       return 7'd64;
      2:       return 7'd0;
      3:       return 7'($urandom_range(65, 127));
      4:       return 7'($urandom_range(2, 4));
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  // result side
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = fast_mode ? 0 : $urandom_range(0, 12);
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (out_tvalid !== 1'b1) @(posedge clk);
      board.check_average(out_tdata);
    end
  end

  initial begin
    int         sent;
    int         phase;
    int         phase_len;
    int         k;
    logic       restart;
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default window; the first word after reset carries no restart
    push_sample(S_MAX, 1'b0);
    push_sample(S_MAX, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MIN, 1'b0);
    push_sample(16'h0000, 1'b0);
    push_sample(16'hffff, 1'b0);
    push_sample(16'h0001, 1'b0);
    push_sample(16'h5555, 1'b0);
    push_sample(16'haaaa, 1'b0);
    push_sample(S_MIN, 1'b1);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MAX, 1'b1);
    wait_averages_done();
    write_window(7'd1);
    push_sample(16'hffff, 1'b0);
    push_sample(S_MIN, 1'b1);
    wait_averages_done();
    // widest window, changed mid-series, then full padding at the top value
    write_window(7'd64);
    push_sample(S_MAX, 1'b0);
    push_sample(S_MAX, 1'b1);
    wait_averages_done();
    write_window(7'd0);
    push_sample(16'h0001, 1'b0);
    push_sample(16'hfffe, 1'b0);
    wait_averages_done();
    write_window(7'd127);
    push_sample(S_MIN, 1'b1);
    push_sample(S_MAX, 1'b0);
    wait_averages_done();
    write_window(7'd65);
    push_sample(16'h1234, 1'b0);
    wait_averages_done();
    write_window(7'd63);
    push_sample(S_MIN, 1'b0);
    push_sample(S_MAX, 1'b0);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_averages_done();
      write_window(rand_window());
      fast_mode = ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(20, 120);
      if (phase == 3) begin
        // receiver stops for a long while, sender keeps pushing
        fast_mode    = 1'b1;
        hold_request = LONG_HOLD;
      end
      for (k = 0; k < phase_len; k++) begin
        restart = (k == 0 && $urandom_range(0, 2) == 0) || ($urandom_range(0, 59) == 0);
        if (phase == 5 && k == phase_len / 2) wait_averages_done();
        push_sample(rand_sample(), restart);
      end
      sent += phase_len;
      phase++;
    end

    wait_averages_done();
    repeat (TAIL_CYCLES) @(posedge clk);
    board.check_drained();
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
